// ===== hw/rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared definitions for the delta timer queue
// Queue geometry, payload widths and the result type of the shared
// subtract/compare unit.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Payload widths.
    localparam int TAG_W   = 8;
    localparam int DELTA_W = 64;
    localparam int POS_W   = 5;

    // Result of the shared subtract/compare unit.
    typedef struct packed {
        logic [DELTA_W-1:0] diff;
        logic               a_gt_b;
    } t_sub_res;

endpackage

// ===== hw/rtl/dtq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dtq_sub_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_sub_unit: shared 64-bit subtract and compare
// Gives a - b and whether a is strictly greater than b.
// ----------------------------------------------------------------------------
module dtq_sub_unit
    import dtq_pkg::*;
(
    input  logic [DELTA_W-1:0] i_a,
    input  logic [DELTA_W-1:0] i_b,
    output t_sub_res           o_res
);

    logic [DELTA_W:0] w_full;

    // A borrow out means a < b; a zero difference means a == b.
    assign w_full       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff   = w_full[DELTA_W-1:0];
    assign o_res.a_gt_b = !w_full[DELTA_W] && (w_full[DELTA_W-1:0] != '0);

endmodule

// ===== hw/rtl/delta_timer_queue_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue_insert: insertion into a delta-list timer queue
// Walks the ordered queue with one shared subtractor, fixes the successor
// delta, shifts the tail down one slot and places the new timer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_timer_tag and i_timer_delay with start high.
//   The transaction is accepted at a rising edge where start is high and
//   busy is low. Unless full, busy then stays high until the insert ends.
//   Result channel: o_valid is high for exactly one cycle with
//   o_stored_delta, o_slot_position and o_queue_full. The receiver cannot
//   stall the block; the result must be taken in that cycle.
//   Sequence: with N entries queued and insert position P, the walk reads
//   one entry per cycle, up to the successor or to the tail. A successor
//   then costs a fix step, a read step and a shift of entries P to N-1
//   down one slot; a place step ends the insert, and an empty queue goes
//   straight to it. The steps run one after another, as each memory has
//   a single read and a single write port. The result shows in the cycle
//   after the place step, and the next transaction can be accepted in
//   that same cycle. A full queue answers in the cycle after acceptance
//   with o_queue_full set.
//   Reset (i_rst_n low, synchronous) empties the queue and the sequencer.
//   The memories are not cleared: only entries below the count are used.
// ----------------------------------------------------------------------------
module delta_timer_queue_insert
    import dtq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [TAG_W-1:0]   i_timer_tag,
    input  logic [DELTA_W-1:0] i_timer_delay,
    output logic               o_valid,
    output logic [DELTA_W-1:0] o_stored_delta,
    output logic [POS_W-1:0]   o_slot_position,
    output logic               o_queue_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FIX,
        S_SHIFT_RD,
        S_SHIFT,
        S_PLACE
    } t_state;

    t_state             r_state, n_state;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [DELTA_W-1:0] r_remain, n_remain;
    logic [DELTA_W-1:0] r_succ, n_succ;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [DELTA_W-1:0] r_stored_delta, n_stored_delta;
    logic [POS_W-1:0]   r_slot, n_slot;
    logic               r_full, n_full;

    // Memory and shared unit controls.
    logic               d_we, tag_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [DELTA_W-1:0] d_wdata, d_rdata;
    logic [TAG_W-1:0]   tag_wdata, tag_rdata;
    logic [DELTA_W-1:0] sub_a, sub_b;
    t_sub_res           sub_res;

    logic [CNT_W-1:0]   w_pos_p1, w_idx_m1, w_idx_m2;

    assign w_pos_p1 = r_pos + CNT_W'(1);
    assign w_idx_m1 = r_idx - CNT_W'(1);
    assign w_idx_m2 = r_idx - CNT_W'(2);

    dtq_ram #(.WIDTH(DELTA_W), .DEPTH(QUEUE_DEPTH)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (w_waddr),
        .i_wdata (d_wdata),
        .i_raddr (w_raddr),
        .o_rdata (d_rdata)
    );

    dtq_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (w_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (w_raddr),
        .o_rdata (tag_rdata)
    );

    dtq_sub_unit u_sub (
        .i_a   (sub_a),
        .i_b   (sub_b),
        .o_res (sub_res)
    );

    // Sequencer next-state and memory control.
    always_comb begin
        n_state        = r_state;
        n_tag          = r_tag;
        n_remain       = r_remain;
        n_succ         = r_succ;
        n_pos          = r_pos;
        n_count        = r_count;
        n_idx          = r_idx;
        n_valid        = 1'b0;
        n_stored_delta = r_stored_delta;
        n_slot         = r_slot;
        n_full         = r_full;
        d_we           = 1'b0;
        tag_we         = 1'b0;
        w_waddr        = r_pos[ADDR_W-1:0];
        w_raddr        = w_pos_p1[ADDR_W-1:0];
        d_wdata        = r_remain;
        tag_wdata      = r_tag;
        sub_a          = r_remain;
        sub_b          = d_rdata;

        case (r_state)
            S_IDLE: begin
                // The head entry is read while the transaction is taken.
                w_raddr = '0;
                if (start) begin
                    if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        n_valid        = 1'b1;
                        n_full         = 1'b1;
                        n_stored_delta = '0;
                        n_slot         = '0;
                    end else begin
                        n_tag    = i_timer_tag;
                        n_remain = i_timer_delay;
                        n_pos    = '0;
                        n_state  = (r_count == '0) ? S_PLACE : S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Step past entries whose delta is strictly smaller.
                if (sub_res.a_gt_b) begin
                    n_remain = sub_res.diff;
                    n_pos    = w_pos_p1;
                    if (w_pos_p1 == r_count) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_succ  = d_rdata;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // Reduce the successor so later expiry times do not move.
                sub_a   = r_succ;
                sub_b   = r_remain;
                d_we    = 1'b1;
                d_wdata = sub_res.diff;
                n_idx   = r_count;
                n_state = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                w_raddr = w_idx_m1[ADDR_W-1:0];
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Move entry idx-1 to idx while reading idx-2.
                d_we      = 1'b1;
                tag_we    = 1'b1;
                w_waddr   = r_idx[ADDR_W-1:0];
                d_wdata   = d_rdata;
                tag_wdata = tag_rdata;
                w_raddr   = w_idx_m2[ADDR_W-1:0];
                n_idx     = w_idx_m1;
                if (w_idx_m1 == r_pos) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                d_we           = 1'b1;
                tag_we         = 1'b1;
                n_count        = r_count + CNT_W'(1);
                n_valid        = 1'b1;
                n_full         = 1'b0;
                n_stored_delta = r_remain;
                n_slot         = POS_W'(r_pos);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_tag          <= n_tag;
        r_remain       <= n_remain;
        r_succ         <= n_succ;
        r_pos          <= n_pos;
        r_idx          <= n_idx;
        r_stored_delta <= n_stored_delta;
        r_slot         <= n_slot;
        r_full         <= n_full;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_stored_delta  = r_stored_delta;
    assign o_slot_position = r_slot;
    assign o_queue_full    = r_full;

endmodule

// ===== hw/rtl/dtq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_checker: port-level checks for the delta timer queue
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module dtq_checker
    import dtq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [DELTA_W-1:0] o_stored_delta,
    input logic [POS_W-1:0]   o_slot_position,
    input logic               o_queue_full
);

    // A result is only shown once the sequencer is back at rest.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Every accepted transaction either starts work or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction made no progress");

    // Finishing an insert always delivers its result.
    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("insert finished without a result");

    // A rejected insert reports slot zero and zero delta.
    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_full) |-> (o_stored_delta == '0 && o_slot_position == '0))
        else $error("full result carries nonzero fields");

endmodule

bind delta_timer_queue_insert dtq_checker u_dtq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_stored_delta  (o_stored_delta),
    .o_slot_position (o_slot_position),
    .o_queue_full    (o_queue_full)
);

// ===== dv/timer_insert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_insert_checker: placement predictor and result checker
// Watches the command and result channels of the delta timer queue, keeps
// its own copy of the queue, predicts where each timer lands and compares
// every result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module timer_insert_checker
    import dtq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [TAG_W-1:0]   i_timer_tag,
    input  logic [DELTA_W-1:0] i_timer_delay,
    input  logic               i_valid,
    input  logic [DELTA_W-1:0] i_stored_delta,
    input  logic [POS_W-1:0]   i_slot_position,
    input  logic               i_queue_full,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int REPORT_LIMIT = 10;

    // One insert result as it appears on the result channel.
    typedef struct packed {
        logic [DELTA_W-1:0] stored_delta;
        logic [POS_W-1:0]   slot_position;
        logic               queue_full;
    } t_placement;

    // Shadow copy of the queue, head first.
    logic [DELTA_W-1:0] delta_copy [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_copy [QUEUE_DEPTH];
    int                 entry_total;
    t_placement         expected_placements [$];

    initial begin
        entry_total  = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Walk the shadow queue, insert the timer and return the placement.
    function automatic t_placement place_timer(input logic [TAG_W-1:0]   tag,
                                               input logic [DELTA_W-1:0] delay);
        t_placement         res;
        logic [DELTA_W-1:0] remain;
        int                 slot;
        int                 k;
        res    = '0;
        remain = delay;
        slot   = 0;
        if (entry_total >= QUEUE_DEPTH) begin
            // A full queue stores nothing and only raises the flag.
            res.queue_full = 1'b1;
        end else begin
            while (slot < entry_total && remain > delta_copy[slot]) begin
                remain = remain - delta_copy[slot];
                slot++;
            end
            // The successor keeps its absolute expiry.
            if (slot < entry_total) begin
                delta_copy[slot] = delta_copy[slot] - remain;
            end
            for (k = entry_total; k > slot; k--) begin
                delta_copy[k] = delta_copy[k-1];
                tag_copy[k]   = tag_copy[k-1];
            end
            delta_copy[slot] = remain;
            tag_copy[slot]   = tag;
            entry_total++;
            res.stored_delta  = remain;
            res.slot_position = slot[POS_W-1:0];
        end
        return res;
    endfunction

    // Compare one observed result with the oldest prediction.
    task automatic check_placement(input t_placement seen);
        t_placement want;
        if (expected_placements.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("unexpected result: delta %016h slot %0d full %0b",
                         seen.stored_delta, seen.slot_position, seen.queue_full);
            end
        end else begin
            want = expected_placements.pop_front();
            if (seen.stored_delta !== want.stored_delta ||
                seen.slot_position !== want.slot_position ||
                seen.queue_full !== want.queue_full) begin
                o_fail_count++;
                if (o_fail_count <= REPORT_LIMIT) begin
                    $display("mismatch: delta %016h/%016h slot %0d/%0d full %0b/%0b",
                             want.stored_delta, seen.stored_delta,
                             want.slot_position, seen.slot_position,
                             want.queue_full, seen.queue_full);
                end
            end
        end
    endtask

    // Predict on every accepted transaction, check on every result strobe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_total = 0;
            expected_placements.delete();
        end else begin
            if (i_start && !i_busy) begin
                expected_placements.push_back(place_timer(i_timer_tag, i_timer_delay));
            end
            if (i_valid) begin
                check_placement(t_placement'{i_stored_delta, i_slot_position,
                                             i_queue_full});
            end
        end
        o_pending = expected_placements.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: delta timer queue insert
// Fills the queue with directed inserts that hit the head, the tail, equal
// deltas, zero and maximum delays, and with random ones, then keeps
// inserting into the full queue with random tags and delays and random idle
// gaps. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import dtq_pkg::*;

    localparam int                 CYCLE_LIMIT    = 200000;
    localparam int                 SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 8;
    localparam int                 RANDOM_INSERTS = 400;
    localparam logic [DELTA_W-1:0] DELAY_MAX      = '1;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic [TAG_W-1:0]   timer_tag   = '0;
    logic [DELTA_W-1:0] timer_delay = '0;
    logic               busy;
    logic               valid;
    logic [DELTA_W-1:0] stored_delta;
    logic [POS_W-1:0]   slot_position;
    logic               queue_full;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    delta_timer_queue_insert DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_timer_tag     (timer_tag),
        .i_timer_delay   (timer_delay),
        .o_valid         (valid),
        .o_stored_delta  (stored_delta),
        .o_slot_position (slot_position),
        .o_queue_full    (queue_full)
    );

    timer_insert_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_timer_tag     (timer_tag),
        .i_timer_delay   (timer_delay),
        .i_valid         (valid),
        .i_stored_delta  (stored_delta),
        .i_slot_position (slot_position),
        .i_queue_full    (queue_full),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Present one insert after an idle gap and hold it until accepted.
    // Start stays high on return so that a zero gap gives back-to-back work.
    task automatic send_insert(input logic [TAG_W-1:0]   tag,
                               input logic [DELTA_W-1:0] delay,
                               input int                 gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        timer_tag   <= tag;
        timer_delay <= delay;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Watchdog on the cycle count.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int               n;
        logic             burst;
        logic [DELTA_W-1:0] delay;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed fill: empty queue, zero delay at the head, equal delta
        // mid-queue, maximum delay at the tail and equal to the tail.
        send_insert(8'h00, 64'd1000, $urandom_range(0, 10));
        send_insert(8'hFF, 64'd0, $urandom_range(0, 10));
        send_insert(8'h01, 64'd1000, $urandom_range(0, 10));
        send_insert(8'h02, DELAY_MAX, $urandom_range(0, 10));
        send_insert(8'h03, 64'd500, $urandom_range(0, 10));
        send_insert(8'h04, DELAY_MAX, $urandom_range(0, 10));
        send_insert(8'h05, 64'd0, $urandom_range(0, 10));
        send_insert(8'hAA, 64'h8000_0000_0000_0000, $urandom_range(0, 10));
        drain_results();
        send_insert(8'h55, 64'd1, $urandom_range(0, 10));
        send_insert(8'h80, DELAY_MAX - 1, $urandom_range(0, 10));

        // Fill the remaining slots with mostly small random delays.
        for (n = 0; n < QUEUE_DEPTH - 10; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                delay = {$urandom, $urandom};
            end else begin
                delay = DELTA_W'($urandom_range(0, 3000));
            end
            send_insert(TAG_W'($urandom_range(0, 255)), delay, $urandom_range(0, 10));
        end
        drain_results();

        // The queue is full now: these must be refused.
        send_insert(8'h00, 64'd0, 0);
        send_insert(8'hFF, DELAY_MAX, 0);
        send_insert(8'h7F, 64'd1, $urandom_range(0, 10));

        // Random inserts with stretches of back-to-back traffic.
        burst = 1'b0;
        for (n = 0; n < RANDOM_INSERTS; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            send_insert(TAG_W'($urandom_range(0, 255)), {$urandom, $urandom},
                        burst ? 0 : $urandom_range(0, 10));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== delta_timer_queue_insert.f =====
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_sub_unit.sv
hw/rtl/delta_timer_queue_insert.sv
hw/rtl/dtq_checker.sv
dv/timer_insert_checker.sv
dv/testbench.sv
